// File: rtl/fsr_pkg.sv
// Shared types, sizes, register indexes and byte helpers for the string replacer.
package fsr_pkg;

  // Sizes
  localparam int NEEDLE_MAX  = 16;
  localparam int REPLACE_MAX = 16;
  localparam int WIN_DEPTH   = NEEDLE_MAX - 1;
  localparam int QDEPTH      = 4;  // power of two

  localparam int NLEN_W    = $clog2(NEEDLE_MAX + 1);
  localparam int RLEN_W    = $clog2(REPLACE_MAX + 1);
  localparam int PEND_W    = $clog2(NEEDLE_MAX);
  localparam int RIDX_W    = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
  localparam int POS_W     = $clog2(REPLACE_MAX + NEEDLE_MAX + 1);
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 4;
  localparam int LEN_CFG_W = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LO   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HI   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LO     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_HI     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LEN    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_ALL = 4'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
    logic       string_empty;
    logic       string_missing;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_empty;
    logic       out_missing;
  } out_word_t;

  typedef struct packed {
    logic [63:0]          needle_low_bytes;
    logic [63:0]          needle_high_bytes;
    logic [LEN_CFG_W-1:0] needle_length;
    logic [63:0]          replacement_low_bytes;
    logic [63:0]          replacement_high_bytes;
    logic [LEN_CFG_W-1:0] replacement_length;
    logic                 fold_case;
    logic                 replace_all;
  } cfg_regs_t;

  // One classified item handed from the front end to the back end
  typedef struct packed {
    logic                        start;     // first item of a string
    logic                        missing;   // answer with a missing word
    logic                        repl;      // emit the replacement first
    logic                        byte_vld;  // then emit data_byte
    logic [7:0]                  data_byte;
    logic                        eos;       // then flush win and close the string
    logic [WIN_DEPTH-1:0][7:0]   win;
    logic [PEND_W-1:0]           win_cnt;
  } fsr_cmd_t;

  function automatic logic [NLEN_W-1:0] sat_nlen(input logic [LEN_CFG_W-1:0] v);
    if (32'(v) > NEEDLE_MAX) return NLEN_W'(NEEDLE_MAX);
    return NLEN_W'(v);
  endfunction

  function automatic logic [RLEN_W-1:0] sat_rlen(input logic [LEN_CFG_W-1:0] v);
    if (32'(v) > REPLACE_MAX) return RLEN_W'(REPLACE_MAX);
    return RLEN_W'(v);
  endfunction

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic logic byte_eq(input logic [7:0] x, input logic [7:0] y,
                                   input logic fold_en);
    if (fold_en) return fold_byte(x) == fold_byte(y);
    return x == y;
  endfunction

endpackage

// File: rtl/fixed_string_replace.sv
// Top level of the fixed-string find and replace block: registers and wiring.
//
// Strings enter one byte per word and one word is taken per cycle while the
// command queue (four entries) has room; every input word turns into one
// command. The back end sends one output word per cycle while the output is
// not stalled: the replacement for a match, an unmatched byte, and at the end
// of a string each byte still waiting in the needle window; the input stalls
// only when these bursts fill the queue. The last byte of each item is held
// in the back end until the next byte of the string or its end arrives.
// Register writes are taken at any time (ready stays high) but must wait until
// the command queue has drained; they reach the next string that starts.
// No clearing pass follows reset.
module fixed_string_replace import fsr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  cfg_regs_t cfg_q;
  fsr_cmd_t  cmd;
  fsr_cmd_t  head;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      head_vld;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers; unknown indexes drop the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_NEEDLE_LO:   cfg_q.needle_low_bytes       <= cfg_data_i;
        REG_NEEDLE_HI:   cfg_q.needle_high_bytes      <= cfg_data_i;
        REG_NEEDLE_LEN:  cfg_q.needle_length          <= cfg_data_i[LEN_CFG_W-1:0];
        REG_REPL_LO:     cfg_q.replacement_low_bytes  <= cfg_data_i;
        REG_REPL_HI:     cfg_q.replacement_high_bytes <= cfg_data_i;
        REG_REPL_LEN:    cfg_q.replacement_length     <= cfg_data_i[LEN_CFG_W-1:0];
        REG_FOLD_CASE:   cfg_q.fold_case              <= cfg_data_i[0];
        REG_REPLACE_ALL: cfg_q.replace_all            <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  fsr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  fsr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .cmd_i      (cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head),
    .head_vld_o (head_vld)
  );

  fsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .head_vld_i  (head_vld),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/fsr_front.sv
// Front end: accepts input words, matches the needle window and issues commands.
module fsr_front import fsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_regs_t cfg_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  input  logic      q_full_i,
  output logic      push_o,
  output fsr_cmd_t  cmd_o
);

  logic                        accept;
  logic                        at_start_q;
  logic                        done_q, done_d, done_e;
  logic [PEND_W-1:0]           pend_q, pend_d, pend_e;
  logic [WIN_DEPTH-1:0][7:0]   win_q, win_d;
  logic [127:0]                nd_all;
  logic [NEEDLE_MAX-1:0][7:0]  nd_q, nd_l, nd_e;
  logic [NLEN_W-1:0]           nlen_q, nlen_l, nlen_e;
  logic                        fold_q, fold_e;
  logic                        all_q, all_e;
  logic                        pre;
  logic                        full_win;
  logic                        hit;
  logic [NEEDLE_MAX-1:0][7:0]  buf_b;
  logic [NEEDLE_MAX-1:0]       lane_ok;
  logic [7:0]                  b;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept;
  assign b          = in_data_i.data_byte;

  // Live register view, used by the first item of a string
  assign nlen_l = sat_nlen(cfg_i.needle_length);
  assign nd_all = {cfg_i.needle_high_bytes, cfg_i.needle_low_bytes};
  assign nd_l   = nd_all[NEEDLE_MAX*8-1:0];

  // Effective per-string settings and state
  assign nlen_e = at_start_q ? nlen_l : nlen_q;
  assign nd_e   = at_start_q ? nd_l : nd_q;
  assign fold_e = at_start_q ? cfg_i.fold_case : fold_q;
  assign all_e  = at_start_q ? cfg_i.replace_all : all_q;
  assign pend_e = at_start_q ? '0 : pend_q;
  assign pre    = at_start_q && (nlen_e == '0) && !all_e;
  assign done_e = (at_start_q ? 1'b0 : done_q) || pre;

  // Candidate window: pending bytes with the new byte appended
  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      buf_b[k] = (PEND_W'(k) == pend_e) ? b : win_q[k];
    end
    buf_b[NEEDLE_MAX-1] = b;
  end

  // Compare all needle lanes in parallel
  always_comb begin
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      lane_ok[k] = (NLEN_W'(k) >= nlen_e) || byte_eq(buf_b[k], nd_e[k], fold_e);
    end
  end

  assign hit      = &lane_ok;
  assign full_win = (NLEN_W'(pend_e) + NLEN_W'(1)) == nlen_e;

  // Classify the word and build the command
  always_comb begin
    cmd_o       = '0;
    win_d       = win_q;
    pend_d      = pend_e;
    done_d      = done_e;
    cmd_o.start = at_start_q;
    cmd_o.repl  = pre;
    if (nlen_e == '0 || done_e) begin
      cmd_o.byte_vld  = 1'b1;
      cmd_o.data_byte = b;
    end else if (full_win) begin
      if (hit) begin
        cmd_o.repl = 1'b1;
        pend_d     = '0;
        if (!all_e) done_d = 1'b1;
      end else begin
        cmd_o.byte_vld  = 1'b1;
        cmd_o.data_byte = buf_b[0];
        for (int k = 0; k < WIN_DEPTH; k++) begin
          win_d[k] = buf_b[k+1];
        end
      end
    end else begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        if (PEND_W'(k) == pend_e) win_d[k] = b;
      end
      pend_d = pend_e + PEND_W'(1);
    end
    cmd_o.eos     = in_data_i.end_of_string;
    cmd_o.win     = win_d;
    cmd_o.win_cnt = pend_d;
    if (in_data_i.string_missing) begin
      cmd_o         = '0;
      cmd_o.missing = 1'b1;
    end else if (in_data_i.string_empty) begin
      cmd_o       = '0;
      cmd_o.start = 1'b1;
      cmd_o.repl  = (nlen_l == '0) && !cfg_i.replace_all;
      cmd_o.eos   = 1'b1;
    end
  end

  // Advance string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      pend_q     <= '0;
      done_q     <= 1'b0;
    end else if (accept) begin
      if (in_data_i.string_missing || in_data_i.string_empty ||
          in_data_i.end_of_string) begin
        at_start_q <= 1'b1;
        pend_q     <= '0;
        done_q     <= 1'b0;
      end else begin
        at_start_q <= 1'b0;
        pend_q     <= pend_d;
        done_q     <= done_d;
      end
    end
  end

  // Hold the window and the settings captured at string start
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
      if (at_start_q) begin
        nd_q   <= nd_l;
        nlen_q <= nlen_l;
        fold_q <= cfg_i.fold_case;
        all_q  <= cfg_i.replace_all;
      end
    end
  end

  a_pend_below_needle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!at_start_q && nlen_q != '0) |-> (NLEN_W'(pend_q) < nlen_q))
    else $error("pending window reached the needle length");

endmodule

// File: rtl/fsr_queue.sv
// Command queue between the front end and the back end.
module fsr_queue import fsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fsr_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output fsr_cmd_t head_o,
  output logic     head_vld_o
);

  fsr_cmd_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  assign full_o     = count_q == QCNT_W'(QDEPTH);
  assign head_vld_o = count_q != '0;
  assign head_o     = mem_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full command queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_vld_o)
    else $error("pop from an empty command queue");

endmodule

// File: rtl/fsr_back.sv
// Back end: expands commands into output words, holding the latest word back.
module fsr_back import fsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_regs_t cfg_i,
  input  fsr_cmd_t  head_i,
  input  logic      head_vld_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic [127:0]                rep_all;
  logic [REPLACE_MAX-1:0][7:0] rep_q, rep_l, rep_e;
  logic [RLEN_W-1:0]           rlen_q, rlen_e, rl;
  logic [POS_W-1:0]            pos_q, pos_d, len, widx;
  logic [7:0]                  held_q, held_d, elem;
  logic                        held_vld_q, held_vld_d;
  logic                        hv;
  logic                        out_free;
  logic                        emit;
  out_word_t                   emit_word;
  logic                        out_valid_q;
  out_word_t                   out_data_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Start commands read the live registers; later ones the captured copy
  assign rep_all = {cfg_i.replacement_high_bytes, cfg_i.replacement_low_bytes};
  assign rep_l   = rep_all[REPLACE_MAX*8-1:0];
  assign rep_e   = head_i.start ? rep_l : rep_q;
  assign rlen_e  = head_i.start ? sat_rlen(cfg_i.replacement_length) : rlen_q;

  // Words produced by the command at the head
  assign rl   = head_i.repl ? rlen_e : '0;
  assign len  = POS_W'(rl) + POS_W'(head_i.byte_vld) +
                (head_i.eos ? POS_W'(head_i.win_cnt) : '0);
  assign widx = pos_q - POS_W'(rl) - POS_W'(head_i.byte_vld);

  always_comb begin
    if (pos_q < POS_W'(rl)) begin
      elem = rep_e[pos_q[RIDX_W-1:0]];
    end else if (head_i.byte_vld && pos_q == POS_W'(rl)) begin
      elem = head_i.data_byte;
    end else begin
      elem = head_i.win[widx[PEND_W-1:0]];
    end
  end

  // A new string drops any word held from an unfinished one
  assign hv = held_vld_q && !(head_i.start && pos_q == '0);

  // Step through the head command, one word per cycle while the output register is free
  always_comb begin
    pop_o      = 1'b0;
    pos_d      = pos_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    emit       = 1'b0;
    emit_word  = '0;
    if (head_vld_i && out_free) begin
      if (head_i.missing) begin
        emit                  = 1'b1;
        emit_word.out_last    = 1'b1;
        emit_word.out_missing = 1'b1;
        held_vld_d            = 1'b0;
        pop_o                 = 1'b1;
      end else if (pos_q < len) begin
        if (hv) begin
          emit               = 1'b1;
          emit_word.out_byte = held_q;
        end
        held_d     = elem;
        held_vld_d = 1'b1;
        if ((pos_q + POS_W'(1)) == len && !head_i.eos) begin
          pop_o = 1'b1;
          pos_d = '0;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end else begin
        if (head_i.eos) begin
          emit               = 1'b1;
          emit_word.out_last = 1'b1;
          if (hv) emit_word.out_byte = held_q;
          else    emit_word.out_empty = 1'b1;
          held_vld_d = 1'b0;
        end else begin
          held_vld_d = hv;
        end
        pop_o = 1'b1;
        pos_d = '0;
      end
    end
  end

  // Advance control state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      held_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      held_vld_q <= held_vld_d;
      if (out_free) out_valid_q <= emit;
    end
  end

  // Hold payloads and capture the replacement at string start
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    if (out_free) out_data_q <= emit_word;
    if (pop_o && head_i.start) begin
      rep_q  <= rep_l;
      rlen_q <= sat_rlen(cfg_i.replacement_length);
    end
  end

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_vld_i && !head_i.missing) |-> (pos_q <= len))
    else $error("command position ran past its length");

  a_drop_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (head_i.missing || head_i.eos)) |=> !held_vld_q)
    else $error("word still held after a string was closed");

  a_flag_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.out_empty || out_data_o.out_missing))
      |-> out_data_o.out_last)
    else $error("flagged word without last");

endmodule

// File: bench/fixed_string_replace_test.sv
// Self-checking bench for the fixed-string replacer: directed and random strings against a predictor.
`timescale 1ns / 100ps

module fixed_string_replace_test;
  import fsr_pkg::*;

  localparam int PERIOD         = 20;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_WORDS    = 16;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_word_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_word_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0]          cfg_data_i  = '0;

  fixed_string_replace dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  // Register copies as written, and the settings used to build stimulus
  logic [63:0] reg_shadow [8] = '{default: '0};
  logic [7:0]  gen_needle [NEEDLE_MAX];
  logic [7:0]  gen_repl [REPLACE_MAX];
  int          gen_nlen = 0;

  // Replacer state as the block should hold it
  logic [7:0]  cur_needle [NEEDLE_MAX];
  logic [7:0]  cur_repl [REPLACE_MAX];
  int          cur_nlen = 0;
  int          cur_rlen = 0;
  bit          cur_fold = 1'b0;
  bit          cur_every = 1'b0;
  logic [7:0]  window_q [$];
  bit          replaced_once = 1'b0;
  bit          string_start = 1'b1;
  bit          held_valid = 1'b0;
  logic [7:0]  held_byte = '0;

  in_word_t    string_words [$];
  out_word_t   rewritten_words [$];
  int          mismatch_count = 0;
  bit          tx_gaps_on = 1'b0;
  bit          rx_stalls_on = 1'b0;
  int          long_hold_req = 0;
  int          quiet_cycles = 0;

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic void expect_word(input logic [7:0] b, input bit last, input bit empty,
                                      input bit missing);
    rewritten_words.push_back('{out_byte: b, out_last: last, out_empty: empty,
                                out_missing: missing});
  endfunction

  // Capture the registers at the start of a string, saturating the lengths
  function automatic void latch_settings();
    int k;
    cur_nlen = int'(reg_shadow[REG_NEEDLE_LEN][4:0]);
    if (cur_nlen > NEEDLE_MAX) cur_nlen = NEEDLE_MAX;
    cur_rlen = int'(reg_shadow[REG_REPL_LEN][4:0]);
    if (cur_rlen > REPLACE_MAX) cur_rlen = REPLACE_MAX;
    cur_fold  = reg_shadow[REG_FOLD_CASE][0];
    cur_every = reg_shadow[REG_REPLACE_ALL][0];
    for (k = 0; k < 8; k++) begin
      cur_needle[k]     = reg_shadow[REG_NEEDLE_LO][8*k +: 8];
      cur_needle[k + 8] = reg_shadow[REG_NEEDLE_HI][8*k +: 8];
      cur_repl[k]       = reg_shadow[REG_REPL_LO][8*k +: 8];
      cur_repl[k + 8]   = reg_shadow[REG_REPL_HI][8*k +: 8];
    end
  endfunction

  function automatic void restart_string();
    window_q.delete();
    replaced_once = 1'b0;
    held_valid    = 1'b0;
    held_byte     = '0;
    string_start  = 1'b1;
  endfunction

  // Work out the output words caused by one accepted input word
  function automatic void rewrite_predict(input in_word_t w);
    logic [7:0] fresh [$];
    logic [7:0] tail [$];
    logic [7:0] x, y;
    bit         hit;
    int         k;
    if (w.string_missing) begin
      restart_string();
      expect_word(8'h00, 1'b1, 1'b0, 1'b1);
      return;
    end
    if (w.string_empty) begin
      latch_settings();
      restart_string();
      if (cur_nlen == 0 && !cur_every && cur_rlen > 0) begin
        for (k = 0; k < cur_rlen; k++) expect_word(cur_repl[k], k == cur_rlen - 1, 1'b0, 1'b0);
      end else begin
        expect_word(8'h00, 1'b1, 1'b1, 1'b0);
      end
      return;
    end
    if (string_start) begin
      latch_settings();
      restart_string();
      string_start = 1'b0;
      // empty needle in first-only mode: prepend the replacement
      if (cur_nlen == 0 && !cur_every) begin
        for (k = 0; k < cur_rlen; k++) fresh.push_back(cur_repl[k]);
        replaced_once = 1'b1;
      end
    end
    if (cur_nlen == 0 || replaced_once) begin
      fresh.push_back(w.data_byte);
    end else begin
      window_q.push_back(w.data_byte);
      if (window_q.size() == cur_nlen) begin
        hit = 1'b1;
        for (k = 0; k < cur_nlen; k++) begin
          x = window_q[k];
          y = cur_needle[k];
          if (cur_fold) begin
            x = to_lower(x);
            y = to_lower(y);
          end
          if (x != y) hit = 1'b0;
        end
        if (hit) begin
          for (k = 0; k < cur_rlen; k++) fresh.push_back(cur_repl[k]);
          window_q.delete();
          if (!cur_every) replaced_once = 1'b1;
        end else begin
          fresh.push_back(window_q.pop_front());
        end
      end
    end
    if (w.end_of_string) begin
      // flush the held byte, the new bytes and the window
      if (held_valid) tail.push_back(held_byte);
      foreach (fresh[k]) tail.push_back(fresh[k]);
      foreach (window_q[k]) tail.push_back(window_q[k]);
      if (tail.size() == 0) begin
        expect_word(8'h00, 1'b1, 1'b1, 1'b0);
      end else begin
        foreach (tail[k]) expect_word(tail[k], k == tail.size() - 1, 1'b0, 1'b0);
      end
      restart_string();
      return;
    end
    // hold back the newest byte so a later end can mark it last
    if (fresh.size() > 0) begin
      if (held_valid) expect_word(held_byte, 1'b0, 1'b0, 1'b0);
      for (k = 0; k + 1 < fresh.size(); k++) expect_word(fresh[k], 1'b0, 1'b0, 1'b0);
      held_byte  = fresh[fresh.size() - 1];
      held_valid = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Input driver: offer queued words, predict each one as it is taken
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) rewrite_predict(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (string_words.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= string_words.pop_front();
          gap_left   = tx_gaps_on ? idle_length() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each taken word, drive the stall pattern
  int        stall_left = 0;
  out_word_t want_word;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (rewritten_words.size() == 0) begin
          $error("output word with nothing pending: byte %02h last %0b empty %0b missing %0b",
                 out_data_o.out_byte, out_data_o.out_last, out_data_o.out_empty,
                 out_data_o.out_missing);
          mismatch_count++;
        end else begin
          want_word = rewritten_words.pop_front();
          check_field("out_byte", want_word.out_byte, out_data_o.out_byte);
          check_field("out_last", want_word.out_last, out_data_o.out_last);
          check_field("out_empty", want_word.out_empty, out_data_o.out_empty);
          check_field("out_missing", want_word.out_missing, out_data_o.out_missing);
        end
      end
      if (long_hold_req > 0) begin
        stall_left    = long_hold_req;
        long_hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = rx_stalls_on ? idle_length() : 0;
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("fixed_string_replace: mismatch");
        $finish;
      end
    end
  end

  // Write one register; call at a rising edge, leaves valid high
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_NEEDLE_LEN, REG_REPL_LEN:     reg_shadow[idx] = {59'd0, value[4:0]};
      REG_FOLD_CASE, REG_REPLACE_ALL:   reg_shadow[idx] = {63'd0, value[0]};
      default: if (idx <= REG_REPLACE_ALL) reg_shadow[idx] = value;
    endcase
  endtask

  // Write every register from the chosen settings, with noise in unused bits and one write to an unknown index
  task automatic apply_settings(input logic [4:0] nl, input logic [4:0] rl, input bit fold_en,
                                input bit every);
    logic [63:0] nlo, nhi, rlo, rhi, noise;
    int          k;
    for (k = 0; k < 8; k++) begin
      nlo[8*k +: 8] = gen_needle[k];
      nhi[8*k +: 8] = gen_needle[k + 8];
      rlo[8*k +: 8] = gen_repl[k];
      rhi[8*k +: 8] = gen_repl[k + 8];
    end
    noise = {$urandom, $urandom};
    write_reg(REG_NEEDLE_LO, nlo);
    write_reg(REG_NEEDLE_HI, nhi);
    write_reg(REG_NEEDLE_LEN, {noise[63:5], nl});
    write_reg(CFG_IDX_W'($urandom_range(8, 15)), {$urandom, $urandom});
    write_reg(REG_REPL_LO, rlo);
    write_reg(REG_REPL_HI, rhi);
    noise = {$urandom, $urandom};
    write_reg(REG_REPL_LEN, {noise[63:5], rl});
    write_reg(REG_FOLD_CASE, {noise[31:0], noise[63:33], fold_en});
    write_reg(REG_REPLACE_ALL, {noise[62:0], every});
    cfg_valid_i <= 1'b0;
    gen_nlen = (nl > NEEDLE_MAX) ? NEEDLE_MAX : int'(nl);
  endtask

  // Wait until every word is sent and answered, then let the pipe drain
  task automatic settle();
    do @(posedge clk_i);
    while (string_words.size() != 0 || in_valid_i || rewritten_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void load_needle(input string s);
    int k;
    for (k = 0; k < NEEDLE_MAX; k++)
      gen_needle[k] = (k < s.len()) ? s[k] : 8'($urandom_range(0, 255));
  endfunction

  function automatic void load_repl(input string s);
    int k;
    for (k = 0; k < REPLACE_MAX; k++)
      gen_repl[k] = (k < s.len()) ? s[k] : 8'($urandom_range(0, 255));
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input bit eos);
    string_words.push_back('{data_byte: b, end_of_string: eos, string_empty: 1'b0,
                             string_missing: 1'b0});
  endfunction

  function automatic void queue_text(input string s, input bit close);
    int k;
    for (k = 0; k < s.len(); k++) queue_byte(s[k], close && k == s.len() - 1);
  endfunction

  function automatic void queue_flag(input bit missing, input bit empty, input bit eos);
    string_words.push_back('{data_byte: 8'($urandom_range(0, 255)), end_of_string: eos,
                             string_empty: empty, string_missing: missing});
  endfunction

  // Small alphabet so needles recur, with the bytes around the fold range
  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 11))
      0, 1, 2: return 8'h61;
      3, 4:    return 8'h62;
      5:       return 8'h41;
      6:       return 8'h42;
      7: begin
        case ($urandom_range(0, 5))
          0:       return 8'h40;
          1:       return 8'h5B;
          2:       return 8'h60;
          3:       return 8'h7B;
          4:       return 8'h5A;
          default: return 8'h7A;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build one string of needle copies, needle prefixes and filler
  function automatic int queue_random_string(input int len, input bit close);
    logic [7:0] text [$];
    logic [7:0] b;
    int         r, cut, k;
    while (text.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 30 && gen_nlen > 0) begin
        cut = (r < 10) ? $urandom_range(1, gen_nlen) : gen_nlen;
        for (k = 0; k < cut; k++) begin
          b = gen_needle[k];
          if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
              $urandom_range(0, 1))
            b = b ^ 8'h20;
          text.push_back(b);
        end
      end else begin
        text.push_back(text_char());
      end
    end
    foreach (text[k]) queue_byte(text[k], close && k == text.size() - 1);
    return text.size();
  endfunction

  // Fill one phase: mostly whole strings, some flagged words and cut strings
  function automatic void queue_phase(input int count);
    int added, r, len;
    bit miss;
    added = 0;
    while (added < count) begin
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      if (r < 6) begin
        queue_flag(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        added++;
      end else if (r < 12) begin
        queue_flag(1'b0, 1'b1, 1'($urandom_range(0, 1)));
        added++;
      end else if (r < 17) begin
        // drop an unfinished string with a flagged word
        added += queue_random_string($urandom_range(1, 6), 1'b0);
        miss = 1'($urandom_range(0, 1));
        queue_flag(miss, !miss || 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        added++;
      end else begin
        added += queue_random_string(len, 1'b1);
      end
    end
  endfunction

  function automatic logic [4:0] pick_length(input int top);
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'(top);
      2:       return 5'($urandom_range(17, 31));
      3:       return 5'd1;
      default: return 5'($urandom_range(2, 5));
    endcase
  endfunction

  initial begin : stimulus
    int         phase, k;
    logic [4:0] nl, rl;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Case folding, replace every hit, flagged words, string cut by an empty word
    load_needle("ab");
    load_repl("XYZ");
    apply_settings(5'd2, 5'd3, 1'b1, 1'b1);
    @(negedge clk_i);
    queue_text("xAbab", 1'b1);
    queue_flag(1'b1, 1'b0, 1'b1);
    queue_flag(1'b1, 1'b1, 1'b0);
    queue_text("a", 1'b0);
    queue_flag(1'b0, 1'b1, 1'b1);
    queue_flag(1'b0, 1'b1, 1'b0);
    settle();

    // Empty needle, first only: prepend, also to an empty string
    load_needle("");
    apply_settings(5'd0, 5'd3, 1'b0, 1'b0);
    @(negedge clk_i);
    queue_flag(1'b0, 1'b1, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    settle();

    // Empty needle, replace every hit: pass through
    apply_settings(5'd0, 5'd3, 1'b0, 1'b1);
    @(negedge clk_i);
    queue_text("hi", 1'b1);
    settle();

    // Empty replacement: first only, then a string replaced away
    load_needle("ab");
    load_repl("");
    apply_settings(5'd2, 5'd0, 1'b0, 1'b0);
    @(negedge clk_i);
    queue_text("abab", 1'b1);
    queue_text("ab", 1'b1);
    settle();

    // Both empty: an empty string stays flagged empty
    apply_settings(5'd0, 5'd0, 1'b0, 1'b0);
    @(negedge clk_i);
    queue_flag(1'b0, 1'b1, 1'b1);
    queue_text("q", 1'b1);
    settle();

    // Random settings and strings
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (k = 0; k < NEEDLE_MAX; k++) gen_needle[k] = text_char();
      for (k = 0; k < REPLACE_MAX; k++)
        gen_repl[k] = $urandom_range(0, 1) ? text_char() : 8'($urandom_range(0, 255));
      nl = pick_length(NEEDLE_MAX);
      rl = pick_length(REPLACE_MAX);
      if (phase == 1) begin
        nl = 5'd31;
        rl = 5'd31;
      end else if (phase == 2) begin
        nl = 5'(NEEDLE_MAX);
        rl = 5'(REPLACE_MAX);
      end
      apply_settings(nl, rl, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      @(negedge clk_i);
      tx_gaps_on   = (phase % 4 == 0) || (phase % 4 == 2);
      rx_stalls_on = (phase % 4 == 0) || (phase % 4 == 3);
      // hold the output off while the sender keeps offering words
      if (phase == 3) begin
        tx_gaps_on    = 1'b0;
        rx_stalls_on  = 1'b0;
        long_hold_req = LONG_HOLD;
      end
      queue_phase(PHASE_WORDS);
      // leave a string open across the next register writes
      if (phase == 6) k = queue_random_string(3, 1'b0);
      settle();
    end

    if (mismatch_count == 0 && rewritten_words.size() == 0) begin
      $display("fixed_string_replace: match");
    end else begin
      $display("fixed_string_replace: mismatch");
    end
    $finish;
  end

endmodule
